// ===== rtl/core/plcm_pkg.sv =====
`default_nettype none
package plcm_pkg;
   localparam int MaxPointsDefault = 16;
   localparam int FracBitsDefault  = 16;
   localparam int KeyW = 32;
   localparam int ColorW = 24;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_LOOKUP = 2'd0;
   localparam logic [1:0] STATUS_INSERT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic             func;
      logic signed [31:0] key_value;
      logic [7:0]       red_in;
      logic [7:0]       green_in;
      logic [7:0]       blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [1:0] status;
   } rsp_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;       // capture request, reset scan index
      logic scan_step;  // read one table entry and advance
      logic shift_step; // move one entry up during insert
      logic write_new;  // write the new point at the insert position
      logic div_start;  // start the three-channel division
      logic respond;    // present result
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_lookup;
      logic full;
      logic scan_done;  // scan found its point or ran off the end
      logic shift_done;
      logic need_div;
      logic div_done;
   } stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/piecewise_linear_color_map_unit.sv =====
// Channel   Direction  Transfer
// req_*     in         start high while busy low
// rsp_*     out        rsp_valid high for one cycle
// Lookup: the scan reads each table entry and then compares it, until it finds
// its point or runs off the end; interpolating adds the three-channel division.
// Insert: entries above the new key are moved up one at a time from the top.
// Reset is synchronous and empties the table. The result lasts one cycle and
// cannot be stalled; busy falls the cycle after it.
`default_nettype none
module piecewise_linear_color_map_unit
   import plcm_pkg::*;
#(
   parameter int MaxPoints = MaxPointsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   cmd_type  cmd;
   stat_type stat;

   plcm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .cmd(cmd), .busy(busy), .done(rsp_valid));

   plcm_datapath #(.MaxPoints(MaxPoints)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd),
      .stat(stat), .rsp(rsp_data));
endmodule
`default_nettype wire

// ===== rtl/core/plcm_div.sv =====
`default_nettype none
// Signed restoring divider, one quotient bit a cycle; truncating quotient.
module plcm_div
   import plcm_pkg::*;
#(
   parameter int NumW = 42,
   parameter int DenW = 34
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [NumW-1:0] num,
   input  wire logic signed [DenW-1:0] den,
   output logic                        done,
   output logic signed [NumW-1:0]      quot
);
   localparam int CntW = $clog2(NumW + 1);

   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0]   r_ff, r_in;
   logic [DenW-1:0] d_ff, d_in;
   logic            neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DenW:0]   trial;
   logic [DenW+1:0] diff;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DenW-1:0], q_ff[NumW-1]};
      diff = {1'b0, trial} - {2'b00, d_ff};
      if (start) begin
         q_in   = num[NumW-1] ? NumW'(-num) : NumW'(num);
         d_in   = den[DenW-1] ? DenW'(-den) : DenW'(den);
         neg_in = num[NumW-1] ^ den[DenW-1];
         r_in   = '0;
         cnt_in = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DenW+1]) begin
            r_in = diff[DenW:0];
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule
`default_nettype wire

// ===== rtl/core/plcm_datapath.sv =====
`default_nettype none
module plcm_datapath
   import plcm_pkg::*;
#(
   parameter int MaxPoints = MaxPointsDefault
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire req_type  req,
   input  wire cmd_type  cmd,
   output stat_type      stat,
   output rsp_type       rsp
);
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);
   localparam int NumW = 42;
   localparam int DenW = 34;

   logic [KeyW-1:0]   key_mem [MaxPoints];
   logic [ColorW-1:0] col_mem [MaxPoints];

   req_type           req_ff;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   idx_ff;
   logic              found_ff, end_ff;
   logic              full_ff;
   logic signed [KeyW-1:0] prev_key_ff, next_key_ff;
   logic [ColorW-1:0] prev_col_ff, next_col_ff;
   logic [CntW-1:0]   sh_ff;  // shift position, counts down
   logic signed [KeyW-1:0] rd_key_ff;
   logic [ColorW-1:0] rd_col_ff;
   logic              rd_vld_ff;
   logic [IdxW-1:0]   rd_addr;

   logic signed [DenW-1:0] span, dv;
   logic signed [NumW-1:0] num [3];
   logic signed [NumW-1:0] quot [3];
   logic [2:0]            ddone;
   rsp_type               rsp_ff, rsp_in;

   // Insert reads the entry below the shift position; lookup reads the scan index.
   assign rd_addr = req_ff.func == FUNC_INSERT ? IdxW'(sh_ff - 1'b1) : IdxW'(idx_ff);

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_col_ff <= col_mem[rd_addr];
      if (cmd.shift_step && rd_vld_ff) begin
         key_mem[IdxW'(sh_ff)] <= rd_key_ff;
         col_mem[IdxW'(sh_ff)] <= rd_col_ff;
      end else if (cmd.write_new) begin
         key_mem[IdxW'(sh_ff)] <= req_ff.key_value;
         col_mem[IdxW'(sh_ff)] <= {req_ff.red_in, req_ff.green_in, req_ff.blue_in};
      end
   end

   // Insert walks from the top: each step either moves an entry up or stops.
   logic stop_shift;
   assign stop_shift = sh_ff == '0 ||
                       (rd_vld_ff && !(req_ff.key_value < $signed(rd_key_ff)));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         idx_ff <= '0;
         sh_ff  <= count_ff;
         full_ff <= count_ff == CntW'(MaxPoints);
         found_ff <= 1'b0;
         end_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         prev_key_ff <= '0;
         prev_col_ff <= '0;
      end else if (cmd.scan_step) begin
         if (!rd_vld_ff) rd_vld_ff <= 1'b1;
         else if (idx_ff == count_ff) end_ff <= 1'b1;
         else if (req_ff.key_value < $signed(rd_key_ff)) begin
            found_ff <= 1'b1;
            next_key_ff <= rd_key_ff;
            next_col_ff <= rd_col_ff;
         end else begin
            prev_key_ff <= rd_key_ff;
            prev_col_ff <= rd_col_ff;
            idx_ff <= idx_ff + 1'b1;
            rd_vld_ff <= 1'b0;
         end
      end else if (cmd.shift_step) begin
         if (!rd_vld_ff) rd_vld_ff <= sh_ff != '0;
         else if (!stop_shift) begin
            sh_ff <= sh_ff - 1'b1;
            rd_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.write_new) count_ff <= count_ff + 1'b1;
   end

   assign span = DenW'(next_key_ff) - DenW'(prev_key_ff);
   assign dv   = DenW'(req_ff.key_value) - DenW'(prev_key_ff);

   for (genvar c = 0; c < 3; c++) begin : g_ch
      logic signed [9:0] cp, cn;
      logic signed [NumW-1:0] num_ff;
      assign cp = {2'b00, prev_col_ff[16-8*c +: 8]};
      assign cn = {2'b00, next_col_ff[16-8*c +: 8]};
      always_ff @(posedge clock) begin
         if (cmd.load) num_ff <= '0;
         else num_ff <= NumW'(cp * span) + NumW'((cn - cp) * dv);
      end
      assign num[c] = num_ff;
      plcm_div #(.NumW(NumW), .DenW(DenW)) u_div (
         .clock(clock), .reset(reset), .start(cmd.div_start),
         .num(num[c]), .den(span), .done(ddone[c]), .quot(quot[c]));
   end

   function automatic logic [7:0] sat8(input logic signed [NumW-1:0] v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   // The full flag is taken when the request is loaded, since an insert
   // that fills the last slot bumps the count before the result is formed.
   always_comb begin
      rsp_in = '0;
      if (req_ff.func == FUNC_INSERT) begin
         rsp_in.status = full_ff ? STATUS_FULL : STATUS_INSERT;
      end else begin
         rsp_in.status = STATUS_LOOKUP;
         if (!found_ff) begin
            {rsp_in.red_out, rsp_in.green_out, rsp_in.blue_out} = prev_col_ff;
         end else if (span != 0) begin
            rsp_in.red_out   = sat8(quot[0]);
            rsp_in.green_out = sat8(quot[1]);
            rsp_in.blue_out  = sat8(quot[2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;
   assign stat.is_lookup  = req_ff.func == FUNC_LOOKUP;
   assign stat.full       = count_ff == CntW'(MaxPoints);
   assign stat.scan_done  = found_ff || end_ff;
   assign stat.shift_done = rd_vld_ff && stop_shift || (sh_ff == '0 && !rd_vld_ff);
   assign stat.need_div   = found_ff && span != 0;
   assign stat.div_done   = ddone[0];
endmodule
`default_nettype wire

// ===== rtl/core/plcm_ctrl.sv =====
`default_nettype none
module plcm_ctrl
   import plcm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          busy,
   output logic          done
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_LOAD  = 8'b00000010,
      S_SCAN  = 8'b00000100,
      S_MUL   = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_SHIFT = 8'b00100000,
      S_RESP  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: state_in = stat.is_lookup ? S_SCAN : (stat.full ? S_RESP : S_SHIFT);
         S_SCAN: begin
            if (stat.scan_done) state_in = stat.need_div ? S_MUL : S_RESP;
            else cmd.scan_step = 1'b1;
         end
         S_MUL: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: if (stat.div_done) state_in = S_RESP;
         S_SHIFT: begin
            if (stat.shift_done) begin
               cmd.write_new = 1'b1;
               state_in = S_RESP;
            end else cmd.shift_step = 1'b1;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= cmd.respond;
      end
   end

   assign busy = state_ff != S_IDLE;
   assign done = done_ff;
endmodule
`default_nettype wire

// ===== rtl/core/plcm_checker.sv =====
`default_nettype none
module plcm_checker
   import plcm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside transfer");
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");
   a_insert_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_LOOKUP |->
      rsp_data.red_out == 0 && rsp_data.green_out == 0 && rsp_data.blue_out == 0)
      else $error("insert color not zero");
endmodule

bind piecewise_linear_color_map_unit plcm_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb
   import plcm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumPoints = 16;
   localparam longint CycleLimit = 400000;

   // Predicts the color map result of each accepted request and holds the
   // expected responses until they come out of the block.
   class color_map_scoreboard;
      logic signed [31:0] keys[NumPoints];
      logic [23:0] colors[NumPoints];
      int count;
      rsp_type pending[$];
      int mismatches;

      function new();
         count = 0;
         mismatches = 0;
      endfunction

      function logic [7:0] blend(int cp, int cn, longint dv, longint span);
         longint num;
         longint q;
         num = longint'(cp) * span + longint'(cn - cp) * dv;
         q = num / span;
         if (q < 0) q = 0;
         if (q > 255) q = 255;
         return q[7:0];
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int pos;
         longint pk, nk;
         logic [23:0] pc, nc;
         bit found;
         e = '0;
         if (r.func == FUNC_INSERT) begin
            if (count >= NumPoints) begin
               e.status = STATUS_FULL;
            end else begin
               pos = count;
               for (int i = 0; i < count; i++) begin
                  if (r.key_value < keys[i]) begin
                     pos = i;
                     break;
                  end
               end
               for (int i = count; i > pos; i--) begin
                  keys[i] = keys[i-1];
                  colors[i] = colors[i-1];
               end
               keys[pos] = r.key_value;
               colors[pos] = {r.red_in, r.green_in, r.blue_in};
               count++;
               e.status = STATUS_INSERT;
            end
         end else begin
            pk = 0;
            pc = '0;
            nk = 0;
            nc = '0;
            found = 0;
            for (int i = 0; i < count; i++) begin
               if (r.key_value < keys[i]) begin
                  found = 1;
                  nk = keys[i];
                  nc = colors[i];
                  break;
               end
               pk = keys[i];
               pc = colors[i];
            end
            e.status = STATUS_LOOKUP;
            if (!found) begin
               {e.red_out, e.green_out, e.blue_out} = pc;
            end else if (nk != pk) begin
               e.red_out = blend(pc[23:16], nc[23:16], longint'(r.key_value) - pk, nk - pk);
               e.green_out = blend(pc[15:8], nc[15:8], longint'(r.key_value) - pk, nk - pk);
               e.blue_out = blend(pc[7:0], nc[7:0], longint'(r.key_value) - pk, nk - pk);
            end
         end
         pending = {pending, e};
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         e = pending.pop_front();
         if (got.red_out !== e.red_out || got.green_out !== e.green_out ||
             got.blue_out !== e.blue_out || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected r=%0d g=%0d b=%0d s=%0d, got r=%0d g=%0d b=%0d s=%0d",
                        e.red_out, e.green_out, e.blue_out, e.status,
                        got.red_out, got.green_out, got.blue_out, got.status);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   int idle_pct = 0;
   longint cycles = 0;
   color_map_scoreboard board;

   piecewise_linear_color_map_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) board.check_response(rsp_data);
      if (!reset && start && !busy) board.note_request(req_data);
      if (cycles > CycleLimit) begin
         $display("piecewise_linear_color_map_unit test failed");
         $finish;
      end
   end

   // Presents one request and holds it until the transfer happens. Start may
   // stay high afterwards, since busy blocks a second transfer until the next
   // request replaces it or the sender goes idle.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      req_data <= r;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] random_key();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'sh8000_0000 + $urandom_range(3);
         2: return 32'sh7fff_ffff - $urandom_range(3);
         3: return $urandom_range(8) - 4;
         default: return ($urandom_range(64) - 32) <<< 16;
      endcase
   endfunction

   function automatic req_type make_request(logic f, logic signed [31:0] k);
      req_type r;
      r.func = f;
      r.key_value = k;
      r.red_in = $urandom;
      r.green_in = $urandom;
      r.blue_in = $urandom;
      return r;
   endfunction

   task automatic wait_drained();
      start <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      req_type r;
      int phase_items;
      board = new();
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty table, zero span with origin, extremes, more inserts.
      send_request(make_request(FUNC_LOOKUP, 32'sd5));
      r = make_request(FUNC_INSERT, 32'sd0);
      r.red_in = 8'hff; r.green_in = 8'h00; r.blue_in = 8'h80;
      send_request(r);
      send_request(make_request(FUNC_LOOKUP, -32'sd1));
      send_request(make_request(FUNC_INSERT, 32'sh7fff_ffff));
      send_request(make_request(FUNC_INSERT, 32'sh8000_0000));
      send_request(make_request(FUNC_LOOKUP, 32'sh8000_0000));
      send_request(make_request(FUNC_LOOKUP, 32'sh7fff_fffe));
      send_request(make_request(FUNC_LOOKUP, 32'sh7fff_ffff));
      send_request(make_request(FUNC_INSERT, 32'sd0));
      send_request(make_request(FUNC_LOOKUP, 32'sd0));
      for (int i = 0; i < 9; i++)
         send_request(make_request(FUNC_INSERT, random_key()));
      send_request(make_request(FUNC_INSERT, 32'sd7));
      send_request(make_request(FUNC_LOOKUP, 32'sh4000_0000));
      send_request(make_request(FUNC_LOOKUP, -32'sh4000_0000));
      wait_drained();

      // The table holds two free slots by now, so the random run mostly looks up,
      // and once its first inserts fill the table the rest are dropped.
      for (int p = 0; p < 3; p++) begin
         idle_pct = (p == 0) ? 37 : (p == 1) ? 57 : 0;
         phase_items = 200;
         for (int i = 0; i < phase_items; i++) begin
            if ($urandom_range(9) == 0)
               send_request(make_request(FUNC_INSERT, random_key()));
            else
               send_request(make_request(FUNC_LOOKUP, random_key()));
         end
      end
      wait_drained();
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("piecewise_linear_color_map_unit test passed");
      else
         $display("piecewise_linear_color_map_unit test failed");
      $finish;
   end
endmodule
`default_nettype wire
